>>> hdl/cva_pkg.sv
// cva_pkg: shared constants, types and the arctangent table for the
// vectoring angle pipeline; used by every module under hdl, no dependencies
package cva_pkg;

  localparam int IN_WIDTH_DEF   = 16;
  localparam int ITERATIONS_DEF = 16;
  localparam int GUARD_BITS_DEF = 4;
  localparam int ANGLE_WIDTH    = 24;
  localparam int TABLE_DEPTH    = 16;

  localparam logic signed [ANGLE_WIDTH-1:0] PI_POS = 24'sd6588397;
  localparam logic signed [ANGLE_WIDTH-1:0] PI_NEG = -24'sd6588398;

  typedef enum logic [1:0] {
    CORR_NONE,
    CORR_POS,
    CORR_NEG
  } corr_t;

  // atan(2^-i) with 21 fractional bits, floored except entries 14 and 15 (rounded up)
  function automatic logic signed [ANGLE_WIDTH-1:0] atan_val(input logic [3:0] idx);
    logic signed [ANGLE_WIDTH-1:0] v;
    unique case (idx)
      4'd0:    v = 24'sd1647099;
      4'd1:    v = 24'sd972339;
      4'd2:    v = 24'sd513757;
      4'd3:    v = 24'sd260791;
      4'd4:    v = 24'sd130901;
      4'd5:    v = 24'sd65514;
      4'd6:    v = 24'sd32765;
      4'd7:    v = 24'sd16383;
      4'd8:    v = 24'sd8191;
      4'd9:    v = 24'sd4095;
      4'd10:   v = 24'sd2047;
      4'd11:   v = 24'sd1023;
      4'd12:   v = 24'sd511;
      4'd13:   v = 24'sd255;
      4'd14:   v = 24'sd128;
      4'd15:   v = 24'sd64;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [ANGLE_WIDTH-1:0] corr_val(input corr_t c);
    logic signed [ANGLE_WIDTH-1:0] v;
    unique case (c)
      CORR_POS: v = PI_POS;
      CORR_NEG: v = PI_NEG;
      default:  v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> hdl/cva_prep.sv
// cva_prep: input stage, folds vectors with negative x into the right half plane
// and records the pi correction; depends on cva_pkg
module cva_prep #(
  parameter int IN_WIDTH   = cva_pkg::IN_WIDTH_DEF,
  parameter int GUARD_BITS = cva_pkg::GUARD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  logic                                  valid_i,
  input  logic signed [IN_WIDTH-1:0]            y_i,
  input  logic signed [IN_WIDTH-1:0]            x_i,
  output logic                                  valid_o,
  output logic signed [IN_WIDTH+GUARD_BITS-1:0] x_o,
  output logic signed [IN_WIDTH+GUARD_BITS-1:0] y_o,
  output cva_pkg::corr_t                        corr_o
);

  localparam int ACC_WIDTH = IN_WIDTH + GUARD_BITS;

  logic signed [ACC_WIDTH-1:0] x_ext;
  logic signed [ACC_WIDTH-1:0] y_ext;
  logic                        valid_r;
  logic signed [ACC_WIDTH-1:0] x_r, x_nxt;
  logic signed [ACC_WIDTH-1:0] y_r, y_nxt;
  cva_pkg::corr_t              corr_r, corr_nxt;

  assign x_ext = {{GUARD_BITS{x_i[IN_WIDTH-1]}}, x_i};
  assign y_ext = {{GUARD_BITS{y_i[IN_WIDTH-1]}}, y_i};

  always_comb begin
    if (x_i[IN_WIDTH-1]) begin
      x_nxt    = -x_ext;
      y_nxt    = -y_ext;
      corr_nxt = y_i[IN_WIDTH-1] ? cva_pkg::CORR_NEG : cva_pkg::CORR_POS;
    end else begin
      x_nxt    = x_ext;
      y_nxt    = y_ext;
      corr_nxt = cva_pkg::CORR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      corr_r <= corr_nxt;
    end
  end

  assign valid_o = valid_r;
  assign x_o     = x_r;
  assign y_o     = y_r;
  assign corr_o  = corr_r;

endmodule

>>> hdl/cva_cell.sv
// cva_cell: one vectoring rotation step with its output register
// depends on cva_pkg for the arctangent table and correction type
module cva_cell #(
  parameter int ACC_WIDTH = cva_pkg::IN_WIDTH_DEF + cva_pkg::GUARD_BITS_DEF,
  parameter int STAGE     = 0
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  logic                                   valid_i,
  input  logic signed [ACC_WIDTH-1:0]            x_i,
  input  logic signed [ACC_WIDTH-1:0]            y_i,
  input  logic signed [cva_pkg::ANGLE_WIDTH-1:0] z_i,
  input  cva_pkg::corr_t                         corr_i,
  output logic                                   valid_o,
  output logic signed [ACC_WIDTH-1:0]            x_o,
  output logic signed [ACC_WIDTH-1:0]            y_o,
  output logic signed [cva_pkg::ANGLE_WIDTH-1:0] z_o,
  output cva_pkg::corr_t                         corr_o
);

  localparam logic signed [cva_pkg::ANGLE_WIDTH-1:0] ATAN = cva_pkg::atan_val(4'(STAGE));

  logic signed [ACC_WIDTH-1:0]            xs;
  logic signed [ACC_WIDTH-1:0]            ys;
  logic                                   valid_r;
  logic signed [ACC_WIDTH-1:0]            x_r, x_nxt;
  logic signed [ACC_WIDTH-1:0]            y_r, y_nxt;
  logic signed [cva_pkg::ANGLE_WIDTH-1:0] z_r, z_nxt;
  cva_pkg::corr_t                         corr_r;

  assign xs = x_i >>> STAGE;
  assign ys = y_i >>> STAGE;

  always_comb begin
    if (!y_i[ACC_WIDTH-1]) begin
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      z_nxt = z_i + ATAN;
    end else begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      z_nxt = z_i - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      corr_r <= corr_i;
    end
  end

  assign valid_o = valid_r;
  assign x_o     = x_r;
  assign y_o     = y_r;
  assign z_o     = z_r;
  assign corr_o  = corr_r;

endmodule

>>> hdl/cordic_vector_angle.sv
// cordic_vector_angle: atan2 of a vector by a chain of vectoring rotation cells
// depends on cva_pkg, cva_prep and cva_cell
//
//   channel   ports                                   direction
//   input     in_valid in_ready in_y_component        into block
//             in_x_component
//   result    out_valid out_ready out_angle           out of block
//
// one item per cycle sustained while results are accepted; the path registers are the
// fold stage, one register per rotation cell and the final correction add
// the whole chain advances together; it holds while a result waits unaccepted
// reset clears only the valid bits of every stage
module cordic_vector_angle #(
  parameter int IN_WIDTH   = cva_pkg::IN_WIDTH_DEF,
  parameter int ITERATIONS = cva_pkg::ITERATIONS_DEF,
  parameter int GUARD_BITS = cva_pkg::GUARD_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [IN_WIDTH-1:0]             in_y_component,
  input  logic signed [IN_WIDTH-1:0]             in_x_component,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [cva_pkg::ANGLE_WIDTH-1:0] out_angle
);

  localparam int ACC_WIDTH = IN_WIDTH + GUARD_BITS;

  logic                                   en;
  logic                                   v_s    [0:ITERATIONS];
  logic signed [ACC_WIDTH-1:0]            x_s    [0:ITERATIONS];
  logic signed [ACC_WIDTH-1:0]            y_s    [0:ITERATIONS];
  logic signed [cva_pkg::ANGLE_WIDTH-1:0] z_s    [0:ITERATIONS];
  cva_pkg::corr_t                         corr_s [0:ITERATIONS];

  logic                                   out_valid_r;
  logic signed [cva_pkg::ANGLE_WIDTH-1:0] angle_r, angle_nxt;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  cva_prep #(
    .IN_WIDTH   (IN_WIDTH),
    .GUARD_BITS (GUARD_BITS)
  ) u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (in_valid),
    .y_i     (in_y_component),
    .x_i     (in_x_component),
    .valid_o (v_s[0]),
    .x_o     (x_s[0]),
    .y_o     (y_s[0]),
    .corr_o  (corr_s[0])
  );

  assign z_s[0] = '0;

  for (genvar g = 0; g < ITERATIONS; g++) begin : g_cell
    cva_cell #(
      .ACC_WIDTH (ACC_WIDTH),
      .STAGE     (g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .valid_i (v_s[g]),
      .x_i     (x_s[g]),
      .y_i     (y_s[g]),
      .z_i     (z_s[g]),
      .corr_i  (corr_s[g]),
      .valid_o (v_s[g+1]),
      .x_o     (x_s[g+1]),
      .y_o     (y_s[g+1]),
      .z_o     (z_s[g+1]),
      .corr_o  (corr_s[g+1])
    );
  end

  assign angle_nxt = z_s[ITERATIONS] + cva_pkg::corr_val(corr_s[ITERATIONS]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v_s[ITERATIONS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_r <= angle_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_angle = angle_r;

endmodule
